### design/md5bd_pkg.sv
// ----------------------------------------------------------------------------
// md5bd_pkg
// Shared types, command codes and constant tables for the MD5 block engine.
// ----------------------------------------------------------------------------
package md5bd_pkg;

  // Block geometry
  localparam int BLOCK_WORDS = 16;
  localparam int WC_W        = $clog2(BLOCK_WORDS);
  localparam int ROUNDS      = 64;
  localparam int RND_W       = $clog2(ROUNDS);

  // Datapath phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PRIME = 2'd1;
  localparam logic [1:0] PH_ROUND = 2'd2;
  localparam logic [1:0] PH_ADD   = 2'd3;

  // Input word
  typedef struct packed {
    logic [31:0] message_word;
    logic        first_of_message;
    logic        last_of_message;
  } in_t;

  // Result word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic [1:0]       phase;
    logic             load;
    logic [RND_W-1:0] round;
    logic             wr_en;
    logic [WC_W-1:0]  wr_addr;
    logic             reload;
    logic [1:0]       emit_idx;
  } cmd_t;

  // Standard initial chaining values
  localparam logic [31:0] MD5_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // Sine-derived round constants
  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Per-round rotate amounts
  localparam logic [4:0] MD5_S [64] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd7, 5'd12, 5'd17, 5'd22,
    5'd7, 5'd12, 5'd17, 5'd22, 5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd5, 5'd9,  5'd14, 5'd20, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd4, 5'd11, 5'd16, 5'd23,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21, 5'd6, 5'd10, 5'd15, 5'd21,
    5'd6, 5'd10, 5'd15, 5'd21, 5'd6, 5'd10, 5'd15, 5'd21
  };

endpackage

### design/md5bd_ctrl.sv
// ----------------------------------------------------------------------------
// md5bd_ctrl
// Sequencer: counts buffered words, steps the 64 rounds, and walks the four
// digest words out.
// ----------------------------------------------------------------------------
module md5bd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              first_of_message,
  input  logic              last_of_message,
  output logic              busy,
  output logic              out_valid,
  output md5bd_pkg::cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_PRIME = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  localparam logic [md5bd_pkg::WC_W-1:0]  WC_LAST  =
    md5bd_pkg::WC_W'(md5bd_pkg::BLOCK_WORDS - 1);
  localparam logic [md5bd_pkg::RND_W-1:0] RND_LAST =
    md5bd_pkg::RND_W'(md5bd_pkg::ROUNDS - 1);

  logic [2:0]                       state_r, state_nxt;
  logic [md5bd_pkg::WC_W-1:0]       wc_r, wc_nxt;
  logic [md5bd_pkg::RND_W-1:0]      round_r, round_nxt;
  logic [1:0]                       idx_r, idx_nxt;
  logic                             last_pend_r, last_pend_nxt;
  logic                             accept;
  logic [md5bd_pkg::WC_W-1:0]       wr_addr;

  assign accept  = start && (state_r == ST_IDLE);
  assign wr_addr = first_of_message ? '0 : wc_r;

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    wc_nxt        = wc_r;
    round_nxt     = round_r;
    idx_nxt       = idx_r;
    last_pend_nxt = last_pend_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          wc_nxt = md5bd_pkg::WC_W'(wr_addr + 1'b1);
          if (wr_addr == WC_LAST) begin
            state_nxt     = ST_LOAD;
            last_pend_nxt = last_of_message;
          end else if (last_of_message) begin
            state_nxt = ST_EMIT;
            wc_nxt    = '0;
            idx_nxt   = 2'd0;
          end
        end
      end
      ST_LOAD: begin
        state_nxt = ST_PRIME;
        round_nxt = '0;
      end
      ST_PRIME: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_r == RND_LAST) begin
          state_nxt = ST_ADD;
          round_nxt = '0;
        end else begin
          round_nxt = md5bd_pkg::RND_W'(round_r + 1'b1);
        end
      end
      ST_ADD: begin
        if (last_pend_r) begin
          state_nxt = ST_EMIT;
          wc_nxt    = '0;
          idx_nxt   = 2'd0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (idx_r == 2'd3) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = 2'(idx_r + 1'b1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wc_r        <= '0;
      round_r     <= '0;
      idx_r       <= 2'd0;
      last_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wc_r        <= wc_nxt;
      round_r     <= round_nxt;
      idx_r       <= idx_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd.phase    = md5bd_pkg::PH_IDLE;
    cmd.load     = (state_r == ST_LOAD);
    cmd.round    = round_r;
    cmd.wr_en    = accept;
    cmd.wr_addr  = wr_addr;
    cmd.reload   = accept && first_of_message;
    cmd.emit_idx = idx_r;
    unique case (state_r)
      ST_PRIME: cmd.phase = md5bd_pkg::PH_PRIME;
      ST_ROUND: cmd.phase = md5bd_pkg::PH_ROUND;
      ST_ADD:   cmd.phase = md5bd_pkg::PH_ADD;
      default:  cmd.phase = md5bd_pkg::PH_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

endmodule

### design/md5bd_datapath.sv
// ----------------------------------------------------------------------------
// md5bd_datapath
// Block buffer, one-round-per-cycle MD5 step unit and chaining registers.
// ----------------------------------------------------------------------------
module md5bd_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  md5bd_pkg::cmd_t   cmd,
  input  logic [31:0]       message_word,
  output md5bd_pkg::out_t   out_data
);

  // Message index used by a round
  function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
    logic [3:0] x;
    logic [3:0] g;
    x = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = x;
      2'd1:    g = 4'(x * 4'd5 + 4'd1);
      2'd2:    g = 4'(x * 4'd3 + 4'd5);
      default: g = 4'(x * 4'd7);
    endcase
    return g;
  endfunction

  // Rotate left by a variable amount
  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

  logic [31:0]  buf_mem [md5bd_pkg::BLOCK_WORDS];
  logic [31:0]  rd_r;
  logic [31:0]  km_r;
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [31:0]  chain_r [4];
  logic [5:0]   rd_rnd;
  logic [5:0]   km_rnd;
  logic [31:0]  f_val;
  logic [31:0]  new_b;

  // Look two rounds ahead for the read, one for the constant sum
  always_comb begin
    case (cmd.phase)
      md5bd_pkg::PH_PRIME: begin
        rd_rnd = 6'd1;
        km_rnd = 6'd0;
      end
      md5bd_pkg::PH_ROUND: begin
        rd_rnd = 6'(cmd.round + 6'd2);
        km_rnd = 6'(cmd.round + 6'd1);
      end
      default: begin
        rd_rnd = 6'd0;
        km_rnd = 6'd0;
      end
    endcase
  end

  // Write arriving words, read the next message word
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      buf_mem[cmd.wr_addr] <= message_word;
    end
    rd_r <= buf_mem[msg_idx(rd_rnd)];
  end

  // Round function
  always_comb begin
    case (cmd.round[5:4])
      2'd0:    f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f_val = (d_r & b_r) | (~d_r & c_r);
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
    new_b = b_r + rotl(f_val + km_r, md5bd_pkg::MD5_S[cmd.round]);
  end

  // Presum constant, message word and the next round's a
  always_ff @(posedge clk) begin
    if (cmd.phase == md5bd_pkg::PH_PRIME) begin
      km_r <= md5bd_pkg::MD5_K[km_rnd] + rd_r + a_r;
    end else if (cmd.phase == md5bd_pkg::PH_ROUND) begin
      km_r <= md5bd_pkg::MD5_K[km_rnd] + rd_r + d_r;
    end
  end

  // Advance the working words
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
    end else if (cmd.phase == md5bd_pkg::PH_ROUND) begin
      a_r <= d_r;
      b_r <= new_b;
      c_r <= b_r;
      d_r <= c_r;
    end
  end

  // Reload or accumulate the chaining words
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reload) begin
      for (int k = 0; k < 4; k++) begin
        chain_r[k] <= md5bd_pkg::MD5_IV[k];
      end
    end else if (cmd.phase == md5bd_pkg::PH_ADD) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
    end
  end

  // Select the digest word on output
  assign out_data.digest_word = chain_r[cmd.emit_idx];
  assign out_data.word_index  = cmd.emit_idx;
  assign out_data.last_word   = (cmd.emit_idx == 2'd3);

endmodule

### design/md5_block_digest_top.sv
// ----------------------------------------------------------------------------
// md5_block_digest_top
// MD5 compression engine: buffers 16 message words, runs 64 rounds, emits
// the four digest words on the last word of a message.
// ----------------------------------------------------------------------------
// A word that neither completes a block nor ends a message leaves busy low; the
//   16th word holds busy high through load, prime, the 64 rounds and the add.
// A last word starts the four digest words in the cycle after acceptance, or right
//   after the compression when it completes a block; one word a cycle.
// No new word is accepted while a block is compressed by the single round unit.
// Reset: synchronous rst_n loads the initial chaining values; the receiver cannot stall.
module md5_block_digest_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  md5bd_pkg::in_t    in_data,
  output logic              busy,
  output logic              out_valid,
  output md5bd_pkg::out_t   out_data
);

  md5bd_pkg::cmd_t cmd;

  md5bd_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .first_of_message (in_data.first_of_message),
    .last_of_message  (in_data.last_of_message),
    .busy             (busy),
    .out_valid        (out_valid),
    .cmd              (cmd)
  );

  md5bd_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .message_word (in_data.message_word),
    .out_data     (out_data)
  );

  // Digest words only while busy
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("digest word outside busy window");

  // Digest words count up without a gap
  a_emit_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_word |=>
      out_valid && out_data.word_index == 2'($past(out_data.word_index) + 2'd1))
    else $error("digest word sequence broken");

  // A digest run opens at word zero
  a_emit_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_data.word_index == 2'd0)
    else $error("digest run does not start at word zero");

  // Final digest word ends the run
  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_word |=> !out_valid)
    else $error("digest run longer than four words");

  // No round work while a digest word is shown
  a_emit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cmd.phase == md5bd_pkg::PH_IDLE && !cmd.load)
    else $error("datapath active during digest output");

endmodule
